// ===== rtl/hcb_pkg.sv =====
// Shared types and constants of the Huffman code builder.
package hcb_pkg;

	localparam int SYMBOL_W = 8;
	localparam int FREQ_W   = 24;
	localparam int WEIGHT_W = 29;
	localparam int CODE_W   = 31;
	localparam int LEN_W    = 5;

	typedef struct packed {
		logic load;
		logic set_used;
		logic scan_init;
		logic trav_init;
		logic scan_issue;
		logic merge;
		logic descend;
		logic emit;
		logic pop;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic build_more;
		logic scan_end;
		logic is_leaf;
		logic stk_empty;
		logic out_taken;
	} status_t;

endpackage

// ===== rtl/hcb_ram.sv =====
// Generic single write port RAM with a registered read port.
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/hcb_ctrl.sv =====
// Sequencer of the Huffman code builder: load, merge scans and tree walk.
module hcb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_symbol,
	input  hcb_pkg::status_t status,
	output hcb_pkg::cmd_t    cmd,
	output logic             in_stall
);
	import hcb_pkg::*;

	typedef enum logic [8:0] {
		S_LOAD  = 9'b000000001,
		S_START = 9'b000000010,
		S_CHECK = 9'b000000100,
		S_SCAN  = 9'b000001000,
		S_DRAIN = 9'b000010000,
		S_MERGE = 9'b000100000,
		S_TREAD = 9'b001000000,
		S_TUSE  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				cmd.load = in_valid;
				if (in_valid && last_symbol) begin
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.set_used = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.scan_init = 1'b1;
				cmd.trav_init = 1'b1;
				state_d = status.build_more ? S_SCAN : S_TREAD;
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.scan_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_MERGE;
			end
			S_MERGE: begin
				cmd.merge = 1'b1;
				state_d = S_CHECK;
			end
			S_TREAD: begin
				state_d = S_TUSE;
			end
			S_TUSE: begin
				if (status.is_leaf) begin
					cmd.emit = 1'b1;
					state_d = S_EMIT;
				end else begin
					cmd.descend = 1'b1;
					state_d = S_TREAD;
				end
			end
			S_EMIT: begin
				if (status.out_taken) begin
					if (status.stk_empty) begin
						cmd.finish = 1'b1;
						state_d = S_LOAD;
					end else begin
						cmd.pop = 1'b1;
						state_d = S_TREAD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	assign in_stall = (state_q != S_LOAD);

endmodule

// ===== rtl/hcb_datapath.sv =====
// Node stores, minimum search, merge and tree walk of the Huffman code builder.
module hcb_datapath #(
	parameter int MAX_SYMBOLS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [hcb_pkg::SYMBOL_W-1:0]   symbol,
	input  logic [hcb_pkg::FREQ_W-1:0]     frequency,
	input  hcb_pkg::cmd_t                  cmd,
	output hcb_pkg::status_t               status,
	output logic [hcb_pkg::SYMBOL_W-1:0]   out_symbol,
	output logic [hcb_pkg::CODE_W-1:0]     code_bits,
	output logic [hcb_pkg::LEN_W-1:0]      code_length,
	output logic                           last_code,
	output logic                           out_valid,
	input  logic                           out_stall
);
	import hcb_pkg::*;

	localparam int NODE_DEPTH = 2 * MAX_SYMBOLS - 1;
	localparam int NW  = $clog2(NODE_DEPTH);
	localparam int LW  = $clog2(MAX_SYMBOLS);
	localparam int CNW = $clog2(MAX_SYMBOLS + 1);
	localparam int EW  = NW + 1;

	logic [CNW-1:0]        count_q;
	logic [NW-1:0]         used_q;
	logic [NODE_DEPTH-1:0] live_q;
	logic [NW-1:0]         scan_idx_q;
	logic                  vld_s1;
	logic                  live_s1;
	logic [NW-1:0]         idx_s1;
	logic                  f1_q, f2_q;
	logic [NW-1:0]         m1_q, m2_q;
	logic [WEIGHT_W-1:0]   w1_q, w2_q;
	logic [NW-1:0]         cur_q;
	logic [CODE_W-1:0]     code_q;
	logic [LEN_W-1:0]      len_q;
	logic [LW-1:0]         sp_q;
	logic [NW-1:0]         stk_node_q [MAX_SYMBOLS];
	logic [CODE_W-1:0]     stk_code_q [MAX_SYMBOLS];
	logic [LEN_W-1:0]      stk_len_q  [MAX_SYMBOLS];

	logic                  room;
	logic                  take1, take2;
	logic                  w_we;
	logic [NW-1:0]         w_waddr;
	logic [WEIGHT_W-1:0]   w_wdata;
	logic [WEIGHT_W-1:0]   w_rdata;
	logic [2*NW-1:0]       ch_rdata;
	logic [NW-1:0]         left_c, right_c;
	logic [SYMBOL_W-1:0]   leaf_rdata;
	logic [LW-1:0]         pop_idx;
	logic                  out_taken;

	assign room    = count_q < CNW'(MAX_SYMBOLS);
	assign w_we    = (cmd.load && room) || cmd.merge;
	assign w_waddr = cmd.merge ? used_q : NW'(count_q);
	assign w_wdata = cmd.merge ? WEIGHT_W'(w1_q + w2_q) : WEIGHT_W'(frequency);

	hcb_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODE_DEPTH)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(scan_idx_q), .rdata(w_rdata)
	);

	hcb_ram #(.WIDTH(2 * NW), .DEPTH(NODE_DEPTH)) u_child (
		.clk(clk), .we(cmd.merge), .waddr(used_q), .wdata({m1_q, m2_q}),
		.raddr(cur_q), .rdata(ch_rdata)
	);

	hcb_ram #(.WIDTH(SYMBOL_W), .DEPTH(MAX_SYMBOLS)) u_leaf (
		.clk(clk), .we(cmd.load && room), .waddr(count_q[LW-1:0]), .wdata(symbol),
		.raddr(cur_q[LW-1:0]), .rdata(leaf_rdata)
	);

	assign left_c  = ch_rdata[2*NW-1:NW];
	assign right_c = ch_rdata[NW-1:0];
	assign pop_idx = sp_q - 1'b1;

	assign take1 = vld_s1 && live_s1 && (!f1_q || (w_rdata < w1_q));
	assign take2 = vld_s1 && live_s1 && !take1 && (!f2_q || (w_rdata < w2_q));

	assign out_taken = out_valid && !out_stall;

	assign status.build_more = (EW'(used_q) + EW'(1)) < (EW'(count_q) << 1);
	assign status.scan_end   = scan_idx_q == (used_q - 1'b1);
	assign status.is_leaf    = EW'(cur_q) < EW'(count_q);
	assign status.stk_empty  = sp_q == '0;
	assign status.out_taken  = out_taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			live_q    <= '0;
			vld_s1    <= 1'b0;
			f1_q      <= 1'b0;
			f2_q      <= 1'b0;
			sp_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_issue;
			if (cmd.load && room) begin
				count_q <= count_q + 1'b1;
				live_q[count_q] <= 1'b1;
			end
			if (cmd.scan_init) begin
				f1_q <= 1'b0;
				f2_q <= 1'b0;
			end else if (take1) begin
				f1_q <= 1'b1;
				f2_q <= f1_q;
			end else if (take2) begin
				f2_q <= 1'b1;
			end
			if (cmd.merge) begin
				live_q[m1_q]   <= 1'b0;
				live_q[m2_q]   <= 1'b0;
				live_q[used_q] <= 1'b1;
			end
			if (cmd.trav_init) begin
				sp_q <= '0;
			end else if (cmd.descend) begin
				sp_q <= sp_q + 1'b1;
			end else if (cmd.pop) begin
				sp_q <= pop_idx;
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_taken) begin
				out_valid <= 1'b0;
			end
			if (cmd.finish) begin
				count_q <= '0;
				live_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		live_s1 <= live_q[scan_idx_q];
		idx_s1  <= scan_idx_q;
		if (cmd.set_used) begin
			used_q <= NW'(count_q);
		end else if (cmd.merge) begin
			used_q <= used_q + 1'b1;
		end
		if (cmd.scan_init) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_issue) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
		if (take1) begin
			m1_q <= idx_s1;
			w1_q <= w_rdata;
			m2_q <= m1_q;
			w2_q <= w1_q;
		end else if (take2) begin
			m2_q <= idx_s1;
			w2_q <= w_rdata;
		end
		if (cmd.trav_init) begin
			cur_q  <= used_q - 1'b1;
			code_q <= '0;
			len_q  <= '0;
		end else if (cmd.descend) begin
			stk_node_q[sp_q] <= right_c;
			stk_code_q[sp_q] <= {code_q[CODE_W-2:0], 1'b1};
			stk_len_q[sp_q]  <= len_q + 1'b1;
			cur_q  <= left_c;
			code_q <= {code_q[CODE_W-2:0], 1'b0};
			len_q  <= len_q + 1'b1;
		end else if (cmd.pop) begin
			cur_q  <= stk_node_q[pop_idx];
			code_q <= stk_code_q[pop_idx];
			len_q  <= stk_len_q[pop_idx];
		end
		if (cmd.emit) begin
			out_symbol  <= leaf_rdata;
			code_bits   <= code_q;
			code_length <= len_q;
			last_code   <= sp_q == '0;
		end
	end

endmodule

// ===== rtl/huffman_code_builder.sv =====
// Huffman code builder top level.
// The block takes one (symbol, frequency) word per cycle while in_stall is low,
// up to MAX_SYMBOLS of them; words beyond that are dropped, and the word marked
// last_symbol starts the build. Each of the n-1 merges scans every node built so
// far once through the node weight memory, one node per cycle, and keeps the two
// lightest live ones. The tree walk then reads each visited node in turn, and
// each code word waits in the output register until it is taken; codes come out
// in left-first order with last_code on the final one. The input stays stalled
// from the last symbol until the final code word is taken.
module huffman_code_builder #(
	parameter int MAX_SYMBOLS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [hcb_pkg::SYMBOL_W-1:0] symbol,
	input  logic [hcb_pkg::FREQ_W-1:0]   frequency,
	input  logic                         last_symbol,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hcb_pkg::SYMBOL_W-1:0] out_symbol,
	output logic [hcb_pkg::CODE_W-1:0]   code_bits,
	output logic [hcb_pkg::LEN_W-1:0]    code_length,
	output logic                         last_code
);
	import hcb_pkg::*;

	cmd_t    cmd;
	status_t status;

	hcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_symbol(last_symbol),
		.status(status), .cmd(cmd), .in_stall(in_stall)
	);

	hcb_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_dp (
		.clk(clk), .arst_n(arst_n), .symbol(symbol), .frequency(frequency),
		.cmd(cmd), .status(status), .out_symbol(out_symbol), .code_bits(code_bits),
		.code_length(code_length), .last_code(last_code), .out_valid(out_valid),
		.out_stall(out_stall)
	);

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the Huffman code builder with its own code predictor.
`timescale 1ns / 100ps

module tb_top;
	import hcb_pkg::*;

	localparam int MAX_SYMBOLS = 32;
	localparam int NODES       = 2 * MAX_SYMBOLS - 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 480;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic [SYMBOL_W-1:0] sym;
		logic [CODE_W-1:0]   code;
		logic [LEN_W-1:0]    len;
		logic                last;
	} code_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SYMBOL_W-1:0] symbol = '0;
	logic [FREQ_W-1:0]   frequency = '0;
	logic                last_symbol = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [SYMBOL_W-1:0] out_symbol;
	logic [CODE_W-1:0]   code_bits;
	logic [LEN_W-1:0]    code_length;
	logic                last_code;

	code_word_t          expected_codes[$];
	logic [SYMBOL_W-1:0] stored_symbols[$];
	logic [FREQ_W-1:0]   stored_freqs[$];
	int                  error_count = 0;
	int                  words_sent = 0;
	int                  codes_seen = 0;
	int                  sets_built = 0;
	int                  cycle_count = 0;
	bit                  idle_enable = 1'b1;
	bit                  hold_request = 1'b0;
	logic                hold_on = 1'b0;

	huffman_code_builder #(.MAX_SYMBOLS(MAX_SYMBOLS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.symbol(symbol), .frequency(frequency), .last_symbol(last_symbol),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_symbol(out_symbol), .code_bits(code_bits),
		.code_length(code_length), .last_code(last_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Builds the tree over the stored leaves and queues the codes in walk order.
	function automatic void predict_codes();
		logic [WEIGHT_W-1:0] weight[NODES];
		int unsigned         left_of[NODES];
		int unsigned         right_of[NODES];
		bit                  live[NODES];
		int unsigned         walk_node[NODES + 1];
		logic [CODE_W-1:0]   walk_code[NODES + 1];
		int unsigned         walk_len[NODES + 1];
		int unsigned         pick[2];
		int unsigned         n, used, best, sp, cnt, nd;
		bit                  found;
		code_word_t          word;
		n = stored_freqs.size();
		for (int i = 0; i < NODES; i++) live[i] = 1'b0;
		for (int i = 0; i < n; i++) begin
			weight[i] = WEIGHT_W'(stored_freqs[i]);
			live[i] = 1'b1;
		end
		used = n;
		while (used - n + 1 < n) begin
			for (int k = 0; k < 2; k++) begin
				best = 0;
				found = 1'b0;
				for (int i = 0; i < used; i++)
					if (live[i] && (!found || weight[i] < weight[best])) begin
						best = i;
						found = 1'b1;
					end
				live[best] = 1'b0;
				pick[k] = best;
			end
			weight[used] = weight[pick[0]] + weight[pick[1]];
			left_of[used] = pick[0];
			right_of[used] = pick[1];
			live[used] = 1'b1;
			used++;
		end
		walk_node[0] = used - 1;
		walk_code[0] = '0;
		walk_len[0] = 0;
		sp = 1;
		cnt = 0;
		while (sp > 0 && cnt < MAX_SYMBOLS) begin
			sp--;
			nd = walk_node[sp];
			if (nd < n) begin
				word.sym = stored_symbols[nd];
				word.code = walk_code[sp];
				word.len = LEN_W'(walk_len[sp]);
				word.last = 1'b0;
				expected_codes.push_back(word);
				cnt++;
			end else if (sp + 2 <= NODES && walk_len[sp] < 31) begin
				walk_node[sp + 1] = left_of[nd];
				walk_code[sp + 1] = walk_code[sp] << 1;
				walk_len[sp + 1] = walk_len[sp] + 1;
				walk_node[sp] = right_of[nd];
				walk_code[sp] = (walk_code[sp] << 1) | 1'b1;
				walk_len[sp] = walk_len[sp] + 1;
				sp += 2;
			end
		end
		if (cnt > 0) expected_codes[expected_codes.size() - 1].last = 1'b1;
		stored_symbols.delete();
		stored_freqs.delete();
		sets_built++;
	endfunction

	task automatic send_word(input logic [SYMBOL_W-1:0] sym, input logic [FREQ_W-1:0] freq,
			input logic last);
		int gap;
		gap = idle_enable ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= sym;
		frequency <= freq;
		last_symbol <= last;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (stored_freqs.size() < MAX_SYMBOLS) begin
			stored_symbols.push_back(sym);
			stored_freqs.push_back(freq);
		end
		if (last) predict_codes();
	endtask

	task automatic send_set(input int count, input int mode);
		logic [FREQ_W-1:0] freq;
		for (int i = 0; i < count; i++) begin
			case (mode)
				0: freq = FREQ_W'($urandom_range(0, 3));
				1: freq = FREQ_W'(1) << $urandom_range(0, FREQ_W - 1);
				default: freq = FREQ_W'($urandom);
			endcase
			send_word(SYMBOL_W'($urandom_range(0, 255)), freq, i == count - 1);
		end
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	initial begin : code_checker
		int wait_left;
		code_word_t want;
		wait_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				codes_seen++;
				if (expected_codes.size() == 0) begin
					$error("code word with no expectation: symbol %0d", out_symbol);
					error_count++;
				end else begin
					want = expected_codes.pop_front();
					if (out_symbol !== want.sym) begin
						$error("out_symbol expected %0d actual %0d", want.sym, out_symbol);
						error_count++;
					end
					if (code_bits !== want.code) begin
						$error("code_bits expected %h actual %h", want.code, code_bits);
						error_count++;
					end
					if (code_length !== want.len) begin
						$error("code_length expected %0d actual %0d", want.len, code_length);
						error_count++;
					end
					if (last_code !== want.last) begin
						$error("last_code expected %0d actual %0d", want.last, last_code);
						error_count++;
					end
				end
				wait_left = idle_enable ? $urandom_range(0, 4) : 0;
			end
			if (hold_on || wait_left > 0) begin
				out_stall <= 1'b1;
				if (!hold_on) wait_left--;
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic test_single_symbol();
		send_word(8'hA5, 24'd7, 1'b1);
		send_word(8'h00, '0, 1'b1);
	endtask

	task automatic test_field_extremes();
		send_word(8'h00, '0, 1'b0);
		send_word(8'hFF, '1, 1'b1);
		send_word(8'hFF, '1, 1'b0);
		send_word(8'h00, '1, 1'b0);
		send_word(8'h80, '0, 1'b1);
	endtask

	task automatic test_ties_and_zero();
		for (int i = 0; i < 5; i++) send_word(8'(i * 3), 24'd4, i == 4);
		for (int i = 0; i < 4; i++) send_word(8'(i + 40), '0, i == 3);
	endtask

	task automatic test_skewed_tree();
		for (int i = 0; i < 8; i++) send_word(8'(200 + i), FREQ_W'(1) << (i * 3), i == 7);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < MAX_SYMBOLS + 2; i++)
			send_word(8'(i), FREQ_W'($urandom_range(0, 1000)), i == MAX_SYMBOLS + 1);
	endtask

	task automatic test_long_hold();
		send_set(MAX_SYMBOLS, 2);
		hold_request = 1'b1;
		send_set(6, 0);
		send_set(3, 2);
	endtask

	task automatic test_random_sets();
		int size;
		while (words_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: size = MAX_SYMBOLS;
				1: size = $urandom_range(MAX_SYMBOLS + 1, MAX_SYMBOLS + 3);
				default: size = $urandom_range(1, 12);
			endcase
			idle_enable = ($urandom_range(0, 5) != 0);
			send_set(size, $urandom_range(0, 2));
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_symbol();
		test_field_extremes();
		test_ties_and_zero();
		test_skewed_tree();
		test_overflow();
		test_long_hold();
		test_random_sets();
		in_valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d symbol words in %0d sets, checked %0d code words.",
			words_sent, sets_built, codes_seen);
		$display("Covered single symbols, ties, zero weights, overflow and long output holds.");
		if (error_count == 0 && expected_codes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
